[design/kec_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kec_pkg
// types and constants shared by the k-mer extract and count unit
// ----------------------------------------------------------------------------
package kec_pkg;

	localparam int KMER_W  = 62;
	localparam int CNT_W   = 16;
	localparam int SLOT_W  = 16;
	localparam int MINC_W  = 7;

	// slot count of the hash table, one slot per slot_index value
	localparam int TABLE_SLOTS = 65536;

	localparam logic [1:0] ST_NONE  = 2'd0;
	localparam logic [1:0] ST_COUNT = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_SLOT  = 2'd3;

	localparam logic OP_BASE = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_T = 8'h54;

	typedef struct packed {
		logic              op;
		logic [7:0]        base_char;
		logic              read_start;
		logic [SLOT_W-1:0] slot_index;
	} kec_in_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [KMER_W-1:0] kmer;
		logic [CNT_W-1:0]  count;
		logic              slot_used;
		logic              passes_cutoff;
	} kec_out_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_PROBE,
		S_WRITE,
		S_SLOT
	} kec_state_t;

	// base coding: A=0 G=1 C=2 T=3, bit 2 flags unknown
	function automatic logic [2:0] base_code(input logic [7:0] c);
		logic [2:0] r;
		case (c)
			CH_A:    r = 3'd0;
			CH_G:    r = 3'd1;
			CH_C:    r = 3'd2;
			CH_T:    r = 3'd3;
			default: r = 3'd4;
		endcase
		return r;
	endfunction

endpackage

[design/kec_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kec_window
// shifts bases into the k-mer window and tracks the valid run length
// ----------------------------------------------------------------------------
module kec_window #(
	parameter int KMER_LEN = 31
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [7:0]              base_char,
	input  logic                    read_start,
	output logic [2*KMER_LEN-1:0]   key,
	output logic                    key_ok
);
	import kec_pkg::*;

	localparam int KW = 2 * KMER_LEN;
	localparam int RW = $clog2(KMER_LEN + 1);

	logic [KW-1:0] window_q;
	logic [RW-1:0] run_q;
	logic [2:0]    code;
	logic [KW-1:0] win_base;
	logic [KW-1:0] win_next;
	logic [RW-1:0] run_base;
	logic [RW-1:0] run_next;

	always_comb begin
		code     = base_code(base_char);
		win_base = read_start ? '0 : window_q;
		run_base = read_start ? '0 : run_q;
		win_next = (win_base >> 2) | (KW'(code[1:0]) << (KW - 2));
		if (code[2]) begin
			win_next = win_base;
			run_next = '0;
		end else if (run_base < RW'(KMER_LEN)) begin
			run_next = run_base + 1'b1;
		end else begin
			run_next = run_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			run_q    <= '0;
		end else if (step) begin
			window_q <= win_next;
			run_q    <= run_next;
		end
	end

	assign key    = win_next;
	assign key_ok = !code[2] && (run_next == RW'(KMER_LEN));

endmodule

[design/kec_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kec_table
// hash table memories: key and count store, slot valid store, with
// registered reads and a clearing pass over the valid store
// ----------------------------------------------------------------------------
module kec_table #(
	parameter int TABLE_SLOTS = 65536,
	parameter int KW          = 62,
	parameter int COUNT_BITS  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_en,
	input  logic [$clog2(TABLE_SLOTS)-1:0] rd_addr,
	output logic [KW-1:0]                  rd_key,
	output logic [COUNT_BITS-1:0]          rd_cnt,
	output logic                           rd_vld,
	input  logic                           wr_en,
	input  logic [$clog2(TABLE_SLOTS)-1:0] wr_addr,
	input  logic [KW-1:0]                  wr_key,
	input  logic [COUNT_BITS-1:0]          wr_cnt,
	output logic                           clr_done
);
	localparam int AW = $clog2(TABLE_SLOTS);

	logic [KW+COUNT_BITS-1:0] data_mem [TABLE_SLOTS];
	logic                     vld_mem  [TABLE_SLOTS];
	logic [AW:0]              clr_q;

	assign clr_done = clr_q[AW] || (clr_q == (AW+1)'(TABLE_SLOTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!clr_done) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			data_mem[wr_addr] <= {wr_key, wr_cnt};
		end
		if (rd_en) begin
			{rd_key, rd_cnt} <= data_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (!clr_done) begin
			vld_mem[clr_q[AW-1:0]] <= 1'b0;
		end else if (wr_en) begin
			vld_mem[wr_addr] <= 1'b1;
		end
		if (rd_en) begin
			rd_vld <= vld_mem[rd_addr];
		end
	end

endmodule

[design/kmer_extract_and_count_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_extract_and_count_unit
// k-mer extractor with an open-addressed counting hash table
// ----------------------------------------------------------------------------
// After reset the unit sweeps its slot valid store with busy high. Each item
// then runs: a character that forms no k-mer is answered directly; a k-mer probes
// from its home slot until it is found or placed in a free slot and written, and
// is dropped with status full after PROBE_LIMIT probes; a slot read reads the
// table and reports that slot. Each probe is a registered table read then a
// compare. The result strobe is high for one cycle and cannot be held off;
// busy falls the cycle after.
module kmer_extract_and_count_unit #(
	parameter int KMER_LEN    = 31,
	parameter int PROBE_LIMIT = 16,
	parameter int COUNT_BITS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  kec_pkg::kec_in_t  item,
	output logic              done,
	output kec_pkg::kec_out_t result,
	input  logic              cfg_we,
	input  logic [6:0]        cfg_wdata
);
	import kec_pkg::*;

	localparam int KW = 2 * KMER_LEN;
	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int PW = $clog2(PROBE_LIMIT + 1);
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	kec_state_t state_q, state_nx;
	kec_in_t    in_q;
	logic [KW-1:0]         key_q;
	logic [AW-1:0]         slot_q;
	logic [PW-1:0]         probe_q;
	logic [MINC_W-1:0]     minc_q;
	kec_out_t              res_q;
	logic                  done_q;
	logic [COUNT_BITS-1:0] newc_q;

	logic [KW-1:0]         w_key;
	logic                  w_ok;
	logic [KW-1:0]         rd_key;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic                  rd_vld;
	logic                  clr_done;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	logic                  accept;
	logic [63:0]           h;
	logic [AW-1:0]         home;
	logic                  hit;
	logic [AW-1:0]         slot_inc;
	logic [COUNT_BITS-1:0] cnt_inc;

	assign accept = start && !busy;

	kec_window #(.KMER_LEN(KMER_LEN)) u_win (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (accept && item.op == OP_BASE),
		.base_char (item.base_char),
		.read_start(item.read_start),
		.key       (w_key),
		.key_ok    (w_ok)
	);

	kec_table #(.TABLE_SLOTS(TABLE_SLOTS), .KW(KW), .COUNT_BITS(COUNT_BITS)) u_tab (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_key  (rd_key),
		.rd_cnt  (rd_cnt),
		.rd_vld  (rd_vld),
		.wr_en   (wr_en),
		.wr_addr (slot_q),
		.wr_key  (key_q),
		.wr_cnt  (newc_q),
		.clr_done(clr_done)
	);

	// home slot of the k-mer being formed
	always_comb begin
		h = 64'(w_key) ^ (64'(w_key) >> 32);
		h = h ^ (h >> 16);
		home = h[AW-1:0];
	end

	assign hit      = rd_vld && (rd_key == key_q);
	assign slot_inc = (32'(slot_q) == TABLE_SLOTS - 1) ? '0 : slot_q + 1'b1;
	assign cnt_inc  = (rd_cnt < CMAX) ? rd_cnt + 1'b1 : rd_cnt;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (item.op == OP_READ) begin
						state_nx = S_SLOT;
					end else if (w_ok) begin
						state_nx = S_READ;
					end
				end
			end
			S_READ: begin
				state_nx = (probe_q == PW'(PROBE_LIMIT)) ? S_IDLE : S_PROBE;
			end
			S_PROBE: begin
				state_nx = (!rd_vld || hit) ? S_WRITE : S_READ;
			end
			S_WRITE: state_nx = S_IDLE;
			S_SLOT:  state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = slot_q;
		wr_en   = 1'b0;
		case (state_q)
			S_READ:  rd_en = (probe_q != PW'(PROBE_LIMIT));
			S_SLOT:  rd_en = 1'b0;
			S_WRITE: wr_en = 1'b1;
			S_IDLE: begin
				rd_en   = accept && item.op == OP_READ;
				rd_addr = item.slot_index[AW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			minc_q  <= 7'd2;
			done_q  <= 1'b0;
			probe_q <= '0;
		end else begin
			state_q <= state_nx;
			done_q  <= 1'b0;
			if (cfg_we) begin
				minc_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					probe_q <= '0;
					if (accept && item.op == OP_BASE && !w_ok) begin
						done_q <= 1'b1;
					end
				end
				S_READ: begin
					if (probe_q == PW'(PROBE_LIMIT)) begin
						done_q <= 1'b1;
					end
				end
				S_PROBE: begin
					probe_q <= probe_q + 1'b1;
				end
				S_WRITE, S_SLOT: done_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// res_q is cleared when the item is taken, so later states set fields only
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					in_q   <= item;
					key_q  <= w_key;
					res_q  <= '0;
				end
			end
			S_READ: begin
				if (probe_q == PW'(PROBE_LIMIT)) begin
					res_q.status <= ST_FULL;
					res_q.kmer   <= KMER_W'(key_q);
				end
			end
			S_PROBE: begin
				if (!rd_vld || hit) begin
					newc_q <= rd_vld ? cnt_inc : COUNT_BITS'(1);
				end else begin
					slot_q <= slot_inc;
				end
			end
			S_WRITE: begin
				res_q.status        <= ST_COUNT;
				res_q.kmer          <= KMER_W'(key_q);
				res_q.count         <= (33'(newc_q) > 33'hFFFF) ? CNT_W'(16'hFFFF)
				                                                 : CNT_W'(newc_q);
				res_q.slot_used     <= 1'b1;
				res_q.passes_cutoff <= 33'(newc_q) >= 33'(minc_q);
			end
			S_SLOT: begin
				res_q.status <= ST_SLOT;
				if (rd_vld && 32'(in_q.slot_index) < TABLE_SLOTS) begin
					res_q.kmer          <= KMER_W'(rd_key);
					res_q.count         <= (33'(rd_cnt) > 33'hFFFF) ? CNT_W'(16'hFFFF)
					                                                : CNT_W'(rd_cnt);
					res_q.slot_used     <= 1'b1;
					res_q.passes_cutoff <= 33'(rd_cnt) >= 33'(minc_q);
				end
			end
			default: ;
		endcase
		if (state_q == S_IDLE && accept && item.op == OP_BASE && w_ok) begin
			slot_q <= home;
		end
	end

	assign busy   = (state_q != S_IDLE) || done_q || !clr_done;
	assign done   = done_q;
	assign result = res_q;

`ifndef SYNTH
	a_write_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WRITE |-> $past(state_q) == S_PROBE)
		else $error("table write without probe");
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> state_q == S_IDLE)
		else $error("result strobe outside idle return");
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_done |-> busy)
		else $error("item taken during clearing pass");
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		probe_q <= PW'(PROBE_LIMIT))
		else $error("probe count past limit");
`endif

endmodule
